/* rtl/mss_pkg.sv */
// shared types, constants and microcode table of the merge sort small sum block
package mss_pkg;

  localparam int MAX_ITEMS_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH       = 25;

  // program labels, one per microcode step
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_PASS,
    ST_RUN,
    ST_READ,
    ST_MERGE,
    ST_RUN_NEXT,
    ST_PASS_NEXT,
    ST_OUT_INIT,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_SEND,
    ST_OUT_TEST,
    ST_CLEAR
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_INIT,
    OP_PASS_START,
    OP_RUN_START,
    OP_MERGE,
    OP_RUN_NEXT,
    OP_PASS_NEXT,
    OP_OUT_INIT,
    OP_OUT_LOAD,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_END,
    C_PASS_DONE,
    C_RUNS_DONE,
    C_RUN_MORE,
    C_OUT_WAIT,
    C_OUT_MORE
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  out_valid;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic end_beat;
    logic pass_done;
    logic runs_done;
    logic run_more;
    logic out_taken;
    logic out_more;
  } flags_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_NONE, cond: C_NEVER, target: ST_LOAD};
    unique case (s)
      ST_LOAD: begin
        c.in_ready = 1'b1;
        c.op       = OP_LOAD;
        c.cond     = C_NOT_END;
        c.target   = ST_LOAD;
      end
      ST_SORT_INIT: c.op = OP_SORT_INIT;
      ST_PASS: begin
        c.op     = OP_PASS_START;
        c.cond   = C_PASS_DONE;
        c.target = ST_OUT_INIT;
      end
      ST_RUN: begin
        c.op     = OP_RUN_START;
        c.cond   = C_RUNS_DONE;
        c.target = ST_PASS_NEXT;
      end
      ST_READ: c.op = OP_NONE;
      ST_MERGE: begin
        c.op     = OP_MERGE;
        c.cond   = C_RUN_MORE;
        c.target = ST_READ;
      end
      ST_RUN_NEXT: begin
        c.op     = OP_RUN_NEXT;
        c.cond   = C_ALWAYS;
        c.target = ST_RUN;
      end
      ST_PASS_NEXT: begin
        c.op     = OP_PASS_NEXT;
        c.cond   = C_ALWAYS;
        c.target = ST_PASS;
      end
      ST_OUT_INIT: c.op = OP_OUT_INIT;
      ST_OUT_READ: c.op = OP_NONE;
      ST_OUT_LOAD: c.op = OP_OUT_LOAD;
      ST_OUT_SEND: begin
        c.out_valid = 1'b1;
        c.cond      = C_OUT_WAIT;
        c.target    = ST_OUT_SEND;
      end
      ST_OUT_TEST: begin
        c.cond   = C_OUT_MORE;
        c.target = ST_OUT_READ;
      end
      ST_CLEAR: begin
        c.op     = OP_CLEAR;
        c.cond   = C_ALWAYS;
        c.target = ST_LOAD;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = ST_LOAD;
      end
    endcase
    return c;
  endfunction

endpackage

/* rtl/mss_if.sv */
// item and result channel interfaces
interface mss_in_if import mss_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface mss_out_if import mss_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sorted_value;
  logic signed [SUM_WIDTH-1:0]   small_sum;
  logic                          overflow;
  logic                          last_out;

  modport source (output valid, sorted_value, small_sum, overflow, last_out, input ready);
  modport sink   (input valid, sorted_value, small_sum, overflow, last_out, output ready);
endinterface

/* rtl/mss_sequencer.sv */
// microcode sequencer: step counter, control store fetch and conditional jumps
module mss_sequencer import mss_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  step_t step, step_next;
  logic  hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

  // control word fetch
  always_comb begin
    ctrl = ucode(step);
  end

  // next step: jump on condition, else fall through
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     hit = 1'b0;
      C_ALWAYS:    hit = 1'b1;
      C_NOT_END:   hit = !flags.end_beat;
      C_PASS_DONE: hit = flags.pass_done;
      C_RUNS_DONE: hit = flags.runs_done;
      C_RUN_MORE:  hit = flags.run_more;
      C_OUT_WAIT:  hit = !flags.out_taken;
      C_OUT_MORE:  hit = flags.out_more;
    endcase
    step_next = hit ? ctrl.target : step_t'(step + 4'd1);
  end

endmodule

/* rtl/merge_sort_small_sum_top.sv */
// top level of the merge sort small sum block: datapath, ping-pong stores, sequencer
//
// usage
//   items:   valid/ready channel of signed values; a beat with last set closes the set
//   results: valid/ready channel, one beat per stored value in ascending order; the
//            final beat carries last_out, the small sum and the overflow flag
//   items are taken one per cycle while loading; beats past MAX_ITEMS are dropped
//   and reported through overflow on the final result
//   after the closing beat the set is merge-sorted bottom-up in ceil(log2 n) passes;
//   each pass alternates between two element stores; each element takes a registered
//   store read, then a compare and write, and each run and each pass add their own
//   start and advance steps
//   each result is read from the store, loaded into the result register, offered and
//   tested for more, and a further result is not read before the last was taken; a
//   stalled receiver holds the result register and the sequencer waits on it
//   no new item is taken until the last result of a set has gone
//   reset (synchronous, rst high) returns the sequencer to loading with an empty set
module merge_sort_small_sum_top import mss_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mss_in_if.sink    items,
  mss_out_if.source results
);

  localparam int CW = $clog2(MAX_ITEMS + 1);  // element counts and pointers
  localparam int AW = $clog2(MAX_ITEMS);      // store addresses
  localparam int LW = CW + 2;                 // run start and width, may overshoot n
  localparam int PW = VALUE_WIDTH + CW + 1;   // product of a value and a run length

  ctrl_t  ctrl;
  flags_t flags;

  // set state
  logic [CW-1:0]               count;
  logic                        dropped;
  logic signed [SUM_WIDTH-1:0] sum;
  logic                        src;      // store that holds the current order

  // merge pointers
  logic [LW-1:0] lo, w;
  logic [CW-1:0] p1, p2, k, mid, hi;

  // element stores, two read ports each
  logic [VALUE_WIDTH-1:0] store0 [MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] store1 [MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] rd_a0, rd_b0, rd_a1, rd_b1;
  logic                   we0, we1;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // merge datapath
  logic signed [VALUE_WIDTH-1:0]  head_a, head_b;
  logic                           left_ok, right_ok, take_left;
  logic [CW-1:0]                  remain;
  logic signed [PW-1:0]           prod;
  logic [LW-1:0]                  lo_w, lo_2w;
  logic                           load_beat, store_room, fin;

  // result register
  logic                          res_valid;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic signed [SUM_WIDTH-1:0]   res_sum;
  logic                          res_over, res_last;

  mss_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign items.ready          = ctrl.in_ready;
  assign res_valid            = ctrl.out_valid;
  assign results.valid        = res_valid;
  assign results.sorted_value = res_value;
  assign results.small_sum    = res_sum;
  assign results.overflow     = res_over;
  assign results.last_out     = res_last;

  assign load_beat  = items.valid && items.ready;
  assign store_room = count < CW'(MAX_ITEMS);

  // heads of the two runs, from the store being read
  assign head_a    = src ? rd_a1 : rd_a0;
  assign head_b    = src ? rd_b1 : rd_b0;
  assign left_ok   = p1 < mid;
  assign right_ok  = p2 < hi;
  // on equal heads the right run goes first
  assign take_left = left_ok && (!right_ok || (head_a < head_b));
  assign remain    = hi - p2;
  assign prod      = PW'(head_a) * PW'($signed({1'b0, remain}));

  assign lo_w  = lo + w;
  assign lo_2w = lo + (w << 1);
  assign fin   = ({1'b0, p1} + 1'b1) == {1'b0, count};

  // sequencer conditions
  assign flags.end_beat  = load_beat && items.last;
  assign flags.pass_done = w >= LW'(count);
  assign flags.runs_done = lo >= LW'(count);
  assign flags.run_more  = ({1'b0, k} + 1'b1) < {1'b0, hi};
  assign flags.out_taken = res_valid && results.ready;
  assign flags.out_more  = p1 < count;

  // store writes: loading fills store 0, a merge writes the store not being read
  always_comb begin
    we0     = 1'b0;
    we1     = 1'b0;
    wr_addr = k[AW-1:0];
    wr_data = take_left ? head_a : head_b;
    if (ctrl.op == OP_LOAD) begin
      we0     = load_beat && store_room;
      wr_addr = count[AW-1:0];
      wr_data = items.value;
    end else if (ctrl.op == OP_MERGE) begin
      we0 = src;
      we1 = !src;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      store0[wr_addr] <= wr_data;
    end
    rd_a0 <= store0[p1[AW-1:0]];
    rd_b0 <= store0[p2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      store1[wr_addr] <= wr_data;
    end
    rd_a1 <= store1[p1[AW-1:0]];
    rd_b1 <= store1[p2[AW-1:0]];
  end

  // control state of the set
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      sum     <= '0;
      src     <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_LOAD: begin
          if (load_beat) begin
            src <= 1'b0;
            if (store_room) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        OP_SORT_INIT: sum <= '0;
        OP_MERGE: begin
          // a smaller left head counts once for every right element still waiting
          if (take_left && right_ok) begin
            sum <= sum + SUM_WIDTH'(prod);
          end
        end
        OP_PASS_NEXT: src <= !src;
        OP_CLEAR: begin
          count   <= '0;
          dropped <= 1'b0;
          sum     <= '0;
        end
        default: ;
      endcase
    end
  end

  // pointers and result register
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_SORT_INIT:  w  <= LW'(1);
      OP_PASS_START: lo <= '0;
      OP_RUN_START: begin
        mid <= (lo_w  < LW'(count)) ? lo_w[CW-1:0]  : count;
        hi  <= (lo_2w < LW'(count)) ? lo_2w[CW-1:0] : count;
        p1  <= lo[CW-1:0];
        p2  <= (lo_w < LW'(count)) ? lo_w[CW-1:0] : count;
        k   <= lo[CW-1:0];
      end
      OP_MERGE: begin
        k <= k + 1'b1;
        if (take_left) begin
          p1 <= p1 + 1'b1;
        end else begin
          p2 <= p2 + 1'b1;
        end
      end
      OP_RUN_NEXT:  lo <= lo_2w;
      OP_PASS_NEXT: w  <= w << 1;
      OP_OUT_INIT:  p1 <= '0;
      OP_OUT_LOAD: begin
        res_value <= head_a;
        res_sum   <= fin ? sum : '0;
        res_over  <= fin ? dropped : 1'b0;
        res_last  <= fin;
        p1        <= p1 + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/mss_checker.sv */
// port-level checks of the merge sort small sum block, bound to the top level
module mss_checker import mss_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_WIDTH-1:0] out_value,
  input logic signed [SUM_WIDTH-1:0]   out_sum,
  input logic                          out_over,
  input logic                          out_last
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("items taken while a result is offered");

  // a closing beat ends loading at once
  a_close_stops_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("items still taken after the closing beat");

  // sum and overflow only on the final result
  a_sum_on_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_sum == '0 && !out_over))
    else $error("sum or overflow shown before the final result");

  // after the final result the block returns to loading, past the test and clear steps
  a_final_ends_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (!out_valid ##2 in_ready))
    else $error("block did not return to loading after the final result");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind merge_sort_small_sum_top mss_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_mss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_last   (items.last),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.sorted_value),
  .out_sum   (results.small_sum),
  .out_over  (results.overflow),
  .out_last  (results.last_out)
);

/* sim/merge_sort_small_sum_top_test.sv */
// self-checking testbench of the merge sort small sum block with its own sorting predictor
module merge_sort_small_sum_top_test;
  import mss_pkg::*;

  localparam int N_MAX      = MAX_ITEMS_DEF;
  localparam int VW         = VALUE_WIDTH_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int LONG_HOLD  = 500;
  localparam int RAND_BEATS = 150;
  localparam int SHOWN_MAX  = 10;

  // one pending item beat; drain_first makes the sender wait for an empty scoreboard
  typedef struct {
    logic signed [VW-1:0] value;
    logic                 last;
    bit                   drain_first;
  } feed_t;

  // one predicted result beat
  typedef struct {
    logic signed [VW-1:0]        sorted_value;
    logic signed [SUM_WIDTH-1:0] small_sum;
    logic                        overflow;
    logic                        last_out;
  } sorted_beat_t;

  logic clk;
  logic rst;

  mss_in_if  #(.VALUE_WIDTH(VW)) items_ch ();
  mss_out_if #(.VALUE_WIDTH(VW)) results_ch ();

  merge_sort_small_sum_top #(
    .MAX_ITEMS  (N_MAX),
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .results(results_ch)
  );

  feed_t        feed_q[$];
  sorted_beat_t sorted_exp_q[$];

  // predictor state: the set being loaded and the merge scratch area
  longint set_vals[N_MAX];
  longint merge_tmp[N_MAX];
  int     set_len;
  bit     set_dropped;

  int  fail_count;
  int  cycle_count;
  bit  item_went;
  bit  hold_go;
  bit  rx_hold;
  int  tx_gap, tx_calm;
  int  rx_gap, rx_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bottom-up merge sort of the loaded set, gathering the small sum on the way;
  // a left value below the current right value counts once per remaining right value,
  // and on a tie the right value goes first with nothing added
  function automatic longint sort_with_small_sum(int n);
    longint acc;
    int     w, lo, mid, hi, p1, p2, k;
    acc = 0;
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo + w < n; lo = lo + 2 * w) begin
        mid = lo + w;
        hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
        p1  = lo;
        p2  = mid;
        k   = lo;
        while (p1 < mid && p2 < hi) begin
          if (set_vals[p1] < set_vals[p2]) begin
            acc = acc + set_vals[p1] * longint'(hi - p2);
            merge_tmp[k] = set_vals[p1];
            p1++;
          end else begin
            merge_tmp[k] = set_vals[p2];
            p2++;
          end
          k++;
        end
        while (p1 < mid) begin
          merge_tmp[k] = set_vals[p1];
          p1++;
          k++;
        end
        while (p2 < hi) begin
          merge_tmp[k] = set_vals[p2];
          p2++;
          k++;
        end
        for (k = lo; k < hi; k++) set_vals[k] = merge_tmp[k];
      end
    end
    return acc;
  endfunction

  // per accepted item beat: store or drop it, and on the closing beat queue the sorted set
  task automatic predict_set_beat(logic signed [VW-1:0] v, logic lst);
    longint       acc;
    sorted_beat_t r;
    if (set_len < N_MAX) begin
      set_vals[set_len] = longint'(v);
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (lst) begin
      acc = sort_with_small_sum(set_len);
      for (int k = 0; k < set_len; k++) begin
        r.sorted_value = set_vals[k][VW-1:0];
        r.last_out     = (k == set_len - 1);
        r.small_sum    = r.last_out ? acc[SUM_WIDTH-1:0] : '0;
        r.overflow     = r.last_out ? set_dropped : 1'b0;
        sorted_exp_q.push_back(r);
      end
      // the first set with dropped items is the cue for the long receiver hold-off
      if (set_dropped) hold_go = 1'b1;
      set_len     = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_sorted_beat(sorted_beat_t got);
    sorted_beat_t want;
    if (sorted_exp_q.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOWN_MAX)
        $display("unexpected result: value %0d sum %0d ovf %0b last %0b",
                 got.sorted_value, got.small_sum, got.overflow, got.last_out);
    end else begin
      want = sorted_exp_q.pop_front();
      if (got.sorted_value !== want.sorted_value || got.small_sum !== want.small_sum ||
          got.overflow !== want.overflow || got.last_out !== want.last_out) begin
        fail_count++;
        if (fail_count <= SHOWN_MAX)
          $display("mismatch: exp value %0d sum %0d ovf %0b last %0b, got %0d %0d %0b %0b",
                   want.sorted_value, want.small_sum, want.overflow, want.last_out,
                   got.sorted_value, got.small_sum, got.overflow, got.last_out);
      end
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // flavour 0: full range, 1: narrow range rich in ties, 2: extremes, near-zero and some full-range values
  function automatic logic signed [VW-1:0] pick_value(int flavour);
    int t;
    case (flavour)
      0: return VW'($urandom);
      1: begin
        t = $urandom_range(0, 8);
        return VW'(t - 4);
      end
      default: begin
        t = $urandom_range(0, 5);
        case (t)
          0: return {1'b1, {(VW-1){1'b0}}};
          1: return {1'b0, {(VW-1){1'b1}}};
          2: return '1;
          3: return '0;
          4: return VW'(1);
          default: return VW'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic push_beat(logic signed [VW-1:0] v, logic lst, bit drain);
    feed_t f;
    f.value       = v;
    f.last        = lst;
    f.drain_first = drain;
    feed_q.push_back(f);
  endtask

  task automatic queue_set(int n, int flavour, bit drain);
    for (int i = 0; i < n; i++) push_beat(pick_value(flavour), i == n - 1, drain && i == 0);
  endtask

  // receiver hold-off in its own process: starts once the first overflowing set has
  // closed, so the block sits on its results while the sender keeps offering beats
  initial begin
    rx_hold = 1'b0;
    while (!hold_go) @(posedge clk);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  // sender: presents the head of the feed queue, changes only on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else if (!items_ch.valid || item_went) begin
      item_went = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        items_ch.valid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        items_ch.valid <= 1'b0;
      end else if (feed_q[0].drain_first && sorted_exp_q.size() != 0) begin
        // pause until every outstanding result has drained
        items_ch.valid <= 1'b0;
      end else begin
        items_ch.valid <= 1'b1;
        items_ch.value <= feed_q[0].value;
        items_ch.last  <= feed_q[0].last;
        if (tx_calm > 0) begin
          tx_calm--;
        end else if ($urandom_range(0, 24) == 0) begin
          tx_calm = $urandom_range(15, 60);
        end else begin
          tx_gap = draw_gap();
        end
      end
    end
  end

  // receiver back-pressure, also on the falling edge
  always @(negedge clk) begin
    if (rst || rx_hold) begin
      results_ch.ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      results_ch.ready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= 1'b1;
      if ($urandom_range(0, 19) == 0) rx_calm = $urandom_range(20, 80);
      else rx_gap = draw_gap();
    end
  end

  // beats on both channels are taken at the rising edge
  always @(posedge clk) begin
    sorted_beat_t got;
    if (!rst) begin
      if (items_ch.valid && items_ch.ready) begin
        predict_set_beat(items_ch.value, items_ch.last);
        void'(feed_q.pop_front());
        item_went = 1'b1;
      end
      if (results_ch.valid && results_ch.ready) begin
        got.sorted_value = results_ch.sorted_value;
        got.small_sum    = results_ch.small_sum;
        got.overflow     = results_ch.overflow;
        got.last_out     = results_ch.last_out;
        check_sorted_beat(got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n, r, total, sets;
    rst              = 1'b1;
    items_ch.valid   = 1'b0;
    items_ch.value   = '0;
    items_ch.last    = 1'b0;
    results_ch.ready = 1'b0;
    set_len          = 0;
    set_dropped      = 1'b0;
    fail_count       = 0;
    cycle_count      = 0;
    item_went        = 1'b0;
    hold_go          = 1'b0;
    tx_gap           = 0;
    tx_calm          = 0;
    rx_gap           = 0;
    rx_calm          = 0;

    // directed: single element at the top of the range
    push_beat(16'sh7fff, 1'b1, 1'b0);
    // both extremes, ascending then descending
    push_beat(16'sh8000, 1'b0, 1'b0);
    push_beat(16'sh7fff, 1'b1, 1'b0);
    push_beat(16'sh7fff, 1'b0, 1'b0);
    push_beat(16'sh8000, 1'b1, 1'b0);
    // all equal: ties take the right side and add nothing
    push_beat(16'sd5, 1'b0, 1'b0);
    push_beat(16'sd5, 1'b0, 1'b0);
    push_beat(16'sd5, 1'b1, 1'b0);
    // mixed signs with repeats
    push_beat(-16'sd1, 1'b0, 1'b0);
    push_beat(16'sd0, 1'b0, 1'b0);
    push_beat(-16'sd1, 1'b0, 1'b0);
    push_beat(16'sd1, 1'b0, 1'b0);
    push_beat(16'sd0, 1'b0, 1'b0);
    push_beat(16'sd2, 1'b1, 1'b0);
    // descending run with alternating bit patterns
    push_beat(16'sd4, 1'b0, 1'b0);
    push_beat(16'sd3, 1'b0, 1'b0);
    push_beat(16'sd2, 1'b0, 1'b0);
    push_beat(16'sd1, 1'b0, 1'b0);
    push_beat(-16'sd2, 1'b0, 1'b0);
    push_beat(16'sh5555, 1'b0, 1'b0);
    push_beat(16'shaaaa, 1'b1, 1'b0);

    // random: a full store plus a dropped closing beat comes first and sets off the
    // long receiver hold-off, then sets mostly small, some up to full, a few overflowing
    queue_set(N_MAX + 1, 0, 1'b0);
    total = N_MAX + 1;
    sets  = 1;
    while (total < RAND_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 8);
      else if (r < 92) n = $urandom_range(9, N_MAX);
      else n = $urandom_range(N_MAX + 1, N_MAX + 4);
      // one set waits for the scoreboard to empty before its first beat
      queue_set(n, $urandom_range(0, 2), sets == 4);
      total += n;
      sets++;
    end

    repeat (4) @(negedge clk);
    rst = 1'b0;

    while (feed_q.size() != 0 || sorted_exp_q.size() != 0) @(posedge clk);
    // let any stray result show up before judging
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
